>>> rtl/alpha_mask_bounding_box_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the alpha mask bounding box block.
// Both macros are clocked on the rising edge and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ALPHA_MASK_BOUNDING_BOX_ASSERT_SVH
`define ALPHA_MASK_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication.
`define AMBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AMBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ambb_pkg.sv
// ---------------------------------------------------------------------------
// ambb_pkg
// Shared types and constants of the alpha mask bounding box block.
// ---------------------------------------------------------------------------
package ambb_pkg;

    localparam int IMG_W_W     = 17;
    localparam int ALPHA_W     = 8;
    localparam int ORIGIN_W    = 48;
    localparam int STEP_W      = 32;
    localparam int BOUND_W     = 50;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 17'd1024;
    localparam logic [ALPHA_W-1:0] THRESHOLD_RST    = 8'd125;
    localparam logic [STEP_W-1:0]  PIXEL_WIDTH_RST  = 32'h0001_0000;
    localparam logic [STEP_W-1:0]  PIXEL_HEIGHT_RST = 32'hFFFF_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_ORIGIN_X     = 3'd2,
        CFG_PIXEL_WIDTH  = 3'd3,
        CFG_ORIGIN_Y     = 3'd4,
        CFG_PIXEL_HEIGHT = 3'd5
    } t_cfg_reg;

    // Settings used by the pixel tracker.
    typedef struct packed {
        logic [IMG_W_W-1:0] image_width;
        logic [ALPHA_W-1:0] alpha_threshold;
    } t_front_cfg;

    // Settings used by the coordinate unit.
    typedef struct packed {
        logic signed [ORIGIN_W-1:0] origin_x;
        logic signed [STEP_W-1:0]   pixel_width;
        logic signed [ORIGIN_W-1:0] origin_y;
        logic signed [STEP_W-1:0]   pixel_height;
    } t_back_cfg;

endpackage

>>> rtl/ambb_front.sv
// ---------------------------------------------------------------------------
// ambb_front
// Pixel tracker: counts columns and rows and keeps the hit extents.
// ---------------------------------------------------------------------------
module ambb_front
    import ambb_pkg::*;
#(
    parameter int MAX_DIM = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_front_cfg                      i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ALPHA_W-1:0]              i_alpha,
    input  logic                            i_last,
    output logic                            o_sum_valid,
    input  logic                            i_sum_ready,
    // {greatest row, least row, greatest column, least column, found}
    output logic [4*$clog2(MAX_DIM):0]      o_sum_data
);

    localparam int IW  = $clog2(MAX_DIM);
    localparam int WW  = IW + 1;

    logic [IW-1:0] r_col, n_col;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_lo_col, n_lo_col;
    logic [IW-1:0] r_hi_col, n_hi_col;
    logic [IW-1:0] r_lo_row, n_lo_row;
    logic [IW-1:0] r_hi_row, n_hi_row;
    logic          r_any, n_any;

    logic [WW-1:0] w_eff;
    logic          hit;
    logic          accept;
    logic          wrap;

    assign o_ready = i_sum_ready;
    assign accept  = i_valid & o_ready;
    assign hit     = i_alpha > i_cfg.alpha_threshold;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff = WW'(1);
        end else if (i_cfg.image_width > IMG_W_W'(MAX_DIM)) begin
            w_eff = WW'(MAX_DIM);
        end else begin
            w_eff = WW'(i_cfg.image_width);
        end
    end

    assign wrap = ({1'b0, r_col} + WW'(1)) >= w_eff;

    always_comb begin
        n_any    = r_any | hit;
        n_lo_col = r_lo_col;
        n_hi_col = r_hi_col;
        n_lo_row = r_lo_row;
        n_hi_row = r_hi_row;
        if (hit && !r_any) begin
            n_lo_col = r_col;
            n_hi_col = r_col;
            n_lo_row = r_row;
            n_hi_row = r_row;
        end else if (hit) begin
            if (r_col < r_lo_col) begin
                n_lo_col = r_col;
            end
            if (r_col > r_hi_col) begin
                n_hi_col = r_col;
            end
            // Rows only grow, so the least row is set by the first hit.
            if (r_row > r_hi_row) begin
                n_hi_row = r_row;
            end
        end

        n_col = r_col + IW'(1);
        n_row = r_row;
        if (wrap) begin
            n_col = '0;
            if (r_row != IW'(MAX_DIM - 1)) begin
                n_row = r_row + IW'(1);
            end
        end
    end

    assign o_sum_valid = accept & i_last;
    assign o_sum_data  = {n_hi_row, n_lo_row, n_hi_col, n_lo_col, n_any};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_lo_col <= '0;
            r_hi_col <= '0;
            r_lo_row <= '0;
            r_hi_row <= '0;
            r_any    <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_col    <= '0;
                r_row    <= '0;
                r_lo_col <= '0;
                r_hi_col <= '0;
                r_lo_row <= '0;
                r_hi_row <= '0;
                r_any    <= 1'b0;
            end else begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_lo_col <= n_lo_col;
                r_hi_col <= n_hi_col;
                r_lo_row <= n_lo_row;
                r_hi_row <= n_hi_row;
                r_any    <= n_any;
            end
        end
    end

endmodule

>>> rtl/ambb_queue.sv
// ---------------------------------------------------------------------------
// ambb_queue
// Small first-in first-out buffer of image summaries.
// ---------------------------------------------------------------------------
module ambb_queue
    import ambb_pkg::*;
#(
    parameter int WIDTH = 65
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_not_full,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_not_full = r_count != CW'(QUEUE_DEPTH);
    assign o_valid    = r_count != '0;
    assign o_data     = r_slot[r_rd_ptr];
    assign do_push    = i_push & o_not_full;
    assign do_pop     = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/ambb_back.sv
// ---------------------------------------------------------------------------
// ambb_back
// Coordinate unit: turns pixel extents into fixed-point geographic bounds.
// ---------------------------------------------------------------------------
module ambb_back
    import ambb_pkg::*;
#(
    parameter int MAX_DIM = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_back_cfg                   i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    // {greatest row, least row, greatest column, least column, found}
    input  logic [4*$clog2(MAX_DIM):0]  i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [4*BOUND_W-1:0]        o_bounds,
    output logic                        o_found
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int PW = IW + 2 + STEP_W;

    logic [IW-1:0]        idx [4];
    logic signed [PW-1:0] prod [4];

    logic                 r_s1_valid;
    logic                 r_s1_found;
    logic signed [PW-1:0] r_s1_prod [4];

    logic                 r_out_valid;
    logic                 r_out_found;
    logic [BOUND_W-1:0]   r_out_bound [4];

    logic                 s1_ready;
    logic                 s2_ready;

    assign s2_ready = !r_out_valid | i_ready;
    assign s1_ready = !r_s1_valid | s2_ready;
    assign o_ready  = s1_ready;

    // Order: least column, greatest column, least row, greatest row.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            idx[k] = i_data[1 + k*IW +: IW];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k < 2) begin
                prod[k] = $signed({1'b0, {1'b0, idx[k]} + (IW+1)'(1)}) * i_cfg.pixel_width;
            end else begin
                prod[k] = $signed({1'b0, {1'b0, idx[k]} + (IW+1)'(1)}) * i_cfg.pixel_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_found <= i_data[0];
            for (int k = 0; k < 4; k++) begin
                r_s1_prod[k] <= prod[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_out_found <= r_s1_found;
            for (int k = 0; k < 4; k++) begin
                if (!r_s1_found) begin
                    r_out_bound[k] <= '0;
                end else if (k < 2) begin
                    r_out_bound[k] <= BOUND_W'(i_cfg.origin_x) + BOUND_W'(r_s1_prod[k]);
                end else begin
                    r_out_bound[k] <= BOUND_W'(i_cfg.origin_y) + BOUND_W'(r_s1_prod[k]);
                end
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_found  = r_out_found;
    assign o_bounds = {r_out_bound[3], r_out_bound[2], r_out_bound[1], r_out_bound[0]};

endmodule

>>> rtl/alpha_mask_bounding_box.sv
// ---------------------------------------------------------------------------
// alpha_mask_bounding_box - threshold mask bounding box in geographic units
// Throughput: one pixel word per cycle; the input stalls only while six results wait.
// The summary of the last pixel passes through the queue and the multiply and add registers to the result word.
// Reset (synchronous, active low) clears counters, queue and output valid, restores settings.
// ---------------------------------------------------------------------------
//
// Alpha bytes of one image arrive in raster order, one word per pixel, with
// tlast on the final pixel. A pixel hits when its alpha is strictly greater
// than the threshold setting. The pixel tracker counts columns and rows and
// keeps the least and greatest hit column and row. When the last pixel is
// taken it pushes a summary of the image into a four-deep queue and clears
// itself, so the next image can start in the very next cycle.
//
// The coordinate unit pulls summaries from the queue. Its first stage forms
// (index + 1) times the pixel step with one multiplier per edge, its second
// stage adds the origin and holds the result word for the output. When no
// pixel hit, all four bounds are zero and tuser is low.
//
// The input stalls once the queue holds four summaries, which can only
// happen while both stages of the coordinate unit hold a word behind a
// stalled output.
//
// Settings are written through the plain write port and must only change
// while no image is in flight and no result is waiting.
module alpha_mask_bounding_box
    import ambb_pkg::*;
#(
    parameter int MAX_DIM = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] alpha
    input  logic                   s_axis_tlast,   // last pixel of the image
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [49:0] min_x, [99:50] max_x, [149:100] max_y, [199:150] min_y
    output logic [4*BOUND_W-1:0]   m_axis_tdata,
    output logic                   m_axis_tuser    // [0] found
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int SUM_W = 4*IW + 1;

    t_front_cfg r_front_cfg;
    t_back_cfg  r_back_cfg;

    logic             sum_push;
    logic             sum_not_full;
    logic [SUM_W-1:0] sum_in;
    logic             sum_valid;
    logic             sum_pop;
    logic [SUM_W-1:0] sum_out;

    // Settings registers. Indices beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cfg.image_width     <= IMAGE_WIDTH_RST;
            r_front_cfg.alpha_threshold <= THRESHOLD_RST;
            r_back_cfg.origin_x         <= '0;
            r_back_cfg.pixel_width      <= PIXEL_WIDTH_RST;
            r_back_cfg.origin_y         <= '0;
            r_back_cfg.pixel_height     <= PIXEL_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_IMAGE_WIDTH: begin
                    r_front_cfg.image_width <= i_cfg_data[IMG_W_W-1:0];
                end
                CFG_THRESHOLD: begin
                    r_front_cfg.alpha_threshold <= i_cfg_data[ALPHA_W-1:0];
                end
                CFG_ORIGIN_X: begin
                    r_back_cfg.origin_x <= i_cfg_data[ORIGIN_W-1:0];
                end
                CFG_PIXEL_WIDTH: begin
                    r_back_cfg.pixel_width <= i_cfg_data[STEP_W-1:0];
                end
                CFG_ORIGIN_Y: begin
                    r_back_cfg.origin_y <= i_cfg_data[ORIGIN_W-1:0];
                end
                CFG_PIXEL_HEIGHT: begin
                    r_back_cfg.pixel_height <= i_cfg_data[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pixel tracker: takes a pixel every cycle while the queue has room.
    ambb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_front_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_alpha     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_sum_valid (sum_push),
        .i_sum_ready (sum_not_full),
        .o_sum_data  (sum_in)
    );

    // Summary queue decouples the tracker from a stalled result consumer.
    ambb_queue #(
        .WIDTH (SUM_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (sum_push),
        .o_not_full (sum_not_full),
        .i_data     (sum_in),
        .o_valid    (sum_valid),
        .i_pop      (sum_pop),
        .o_data     (sum_out)
    );

    // Coordinate unit: multiply stage, then add stage that is the output register.
    ambb_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_back_cfg),
        .i_valid  (sum_valid),
        .o_ready  (sum_pop),
        .i_data   (sum_out),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_bounds (m_axis_tdata),
        .o_found  (m_axis_tuser)
    );

endmodule

>>> rtl/ambb_checker.sv
// ---------------------------------------------------------------------------
// ambb_checker
// Port-level checks of the alpha mask bounding box, bound to the top level.
// ---------------------------------------------------------------------------
`include "alpha_mask_bounding_box_assert.svh"

module ambb_checker
    import ambb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic                 i_s_tlast,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [4*BOUND_W-1:0] i_m_tdata,
    input  logic                 i_m_tuser
);

    // A stalled result word stays put.
    `AMBB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "result word changed while stalled")

    // An image without a hit reports all bounds as zero.
    `AMBB_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser, i_m_tdata == '0, "bounds not zero on an image without hits")

    // The pixel input only stalls after a last pixel has filled the queue.
    `AMBB_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, $fell(i_s_tready), $past(i_s_tvalid && i_s_tready && i_s_tlast), "input stalled without a finished image")

endmodule

bind alpha_mask_bounding_box ambb_checker u_ambb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tlast  (s_axis_tlast),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
